/* rtl/assert_macros.svh */
// assert_macros.svh: assertion macros used by the utf-8 scan rtl
// depends on signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CHK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked in the cycle after a trigger
`define ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) else $error(msg);

`endif

/* rtl/utf8ds_pkg.sv */
// utf8ds_pkg: byte classes, status codes and queue entry type for utf8_decode_scan
// no dependencies
`timescale 1ns / 1ps

package utf8ds_pkg;

   // default saturation limit of the character count
   localparam longint unsigned MAX_CHARS_DEF = 64'd65536;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // field widths
   localparam int CP_W    = 21;
   localparam int CNT_O_W = 17;
   localparam int IDX_W   = 16;
   localparam int CLS_W   = 3;

   // byte classes
   localparam logic [CLS_W-1:0] CLS_ASCII = 3'd0;
   localparam logic [CLS_W-1:0] CLS_LEAD2 = 3'd1;
   localparam logic [CLS_W-1:0] CLS_LEAD3 = 3'd2;
   localparam logic [CLS_W-1:0] CLS_LEAD4 = 3'd3;
   localparam logic [CLS_W-1:0] CLS_CONT  = 3'd4;
   localparam logic [CLS_W-1:0] CLS_BAD   = 3'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_TRUNC   = 2'd2;

   // one classified byte as it travels through the queue
   typedef struct packed {
      logic [CLS_W-1:0] cls;
      logic [7:0]       data;
      logic             eos;
   } entry_type;

endpackage

/* rtl/utf8ds_front.sv */
// utf8ds_front: classifies each incoming byte by its utf-8 role
// depends on utf8ds_pkg
`timescale 1ns / 1ps

module utf8ds_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_string,
   input  logic                  q_ready,
   output logic                  q_push,
   output utf8ds_pkg::entry_type q_entry
);

   logic [utf8ds_pkg::CLS_W-1:0] cls;

   // decode the prefix bits of the byte
   always_comb begin
      if (req_data_byte[7] == 1'b0) begin
         cls = utf8ds_pkg::CLS_ASCII;
      end else if (req_data_byte[7:6] == 2'b10) begin
         cls = utf8ds_pkg::CLS_CONT;
      end else if (req_data_byte[7:5] == 3'b110) begin
         cls = utf8ds_pkg::CLS_LEAD2;
      end else if (req_data_byte[7:4] == 4'b1110) begin
         cls = utf8ds_pkg::CLS_LEAD3;
      end else if (req_data_byte[7:3] == 5'b11110) begin
         cls = utf8ds_pkg::CLS_LEAD4;
      end else begin
         cls = utf8ds_pkg::CLS_BAD;
      end
   end

   // accept whenever the queue has room
   assign req_ready     = q_ready;
   assign q_push        = req_valid && q_ready;
   assign q_entry.cls   = cls;
   assign q_entry.data  = req_data_byte;
   assign q_entry.eos   = req_end_of_string;

endmodule

/* rtl/utf8ds_queue.sv */
// utf8ds_queue: short fifo of classified bytes between front and back
// depends on utf8ds_pkg
`timescale 1ns / 1ps

module utf8ds_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utf8ds_pkg::entry_type push_entry,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  pop_valid,
   output utf8ds_pkg::entry_type pop_entry
);

   localparam int DEPTH = utf8ds_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   utf8ds_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign push_ready = (fill_ff != CNT_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/utf8ds_back.sv */
// utf8ds_back: sequence decoder, character count, target tracking and result register
// depends on utf8ds_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8ds_back #(
   parameter longint unsigned MAX_CHARS = utf8ds_pkg::MAX_CHARS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [20:0]           csr_wr_data,
   input  logic                  q_valid,
   input  utf8ds_pkg::entry_type q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_char_done,
   output logic [20:0]           rsp_code_point,
   output logic [2:0]            rsp_char_bytes,
   output logic [1:0]            rsp_status,
   output logic                  rsp_string_done,
   output logic [16:0]           rsp_char_count,
   output logic                  rsp_first_found,
   output logic [15:0]           rsp_first_index,
   output logic                  rsp_last_found,
   output logic [15:0]           rsp_last_index
);

   localparam int CNT_W = $clog2(MAX_CHARS + 64'd1);
   localparam int CP_W  = utf8ds_pkg::CP_W;
   localparam int IDX_W = utf8ds_pkg::IDX_W;

   // configuration
   logic [CP_W-1:0] target_ff;

   // decoder state
   logic [CP_W-1:0]  pv_ff, pv_in;
   logic [2:0]       need_ff, need_in;
   logic [2:0]       seen_ff, seen_in;
   logic             pbad_ff, pbad_in;
   logic             sbad_ff, sbad_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ffound_ff, ffound_in;
   logic [IDX_W-1:0] fpos_ff, fpos_in;
   logic             lfound_ff, lfound_in;
   logic [IDX_W-1:0] lpos_ff, lpos_in;

   // result register
   logic             valid_ff;
   logic             done_ff;
   logic [CP_W-1:0]  cp_ff;
   logic [2:0]       len_ff;
   logic [1:0]       status_ff;
   logic             eos_ff;
   logic [16:0]      ocount_ff;
   logic             ofound_ff;
   logic [IDX_W-1:0] ofpos_ff;
   logic             olfound_ff;
   logic [IDX_W-1:0] olpos_ff;

   logic             done;
   logic [CP_W-1:0]  cp;
   logic [2:0]       len;
   logic [1:0]       status;
   logic             cont_bad;
   logic [CP_W-1:0]  pv_shift;
   logic [2:0]       seen_inc;
   logic             saturated;
   logic [32:0]      count_x;
   logic [7:0]       b;

   assign b         = q_entry.data;
   assign q_pop     = q_valid && (!valid_ff || rsp_ready);
   assign saturated = (count_ff >= CNT_W'(MAX_CHARS));
   assign count_x   = 33'(count_ff);
   assign cont_bad  = (q_entry.cls != utf8ds_pkg::CLS_CONT);
   assign pv_shift  = {pv_ff[CP_W-7:0], b[5:0]};
   assign seen_inc  = seen_ff + 3'd1;

   // one byte step of the decoder
   always_comb begin
      pv_in     = pv_ff;
      need_in   = need_ff;
      seen_in   = seen_ff;
      pbad_in   = pbad_ff;
      sbad_in   = sbad_ff;
      count_in  = count_ff;
      ffound_in = ffound_ff;
      fpos_in   = fpos_ff;
      lfound_in = lfound_ff;
      lpos_in   = lpos_ff;
      done      = 1'b0;
      cp        = '0;
      len       = '0;
      if (!sbad_ff) begin
         if (need_ff == 3'd0) begin
            // between characters: look at the leading byte
            case (q_entry.cls)
               utf8ds_pkg::CLS_ASCII: begin
                  done = 1'b1;
                  cp   = CP_W'(b[6:0]);
                  len  = 3'd1;
               end
               utf8ds_pkg::CLS_LEAD2: begin
                  need_in = 3'd2;
                  pv_in   = CP_W'(b[4:0]);
               end
               utf8ds_pkg::CLS_LEAD3: begin
                  need_in = 3'd3;
                  pv_in   = CP_W'(b[3:0]);
               end
               utf8ds_pkg::CLS_LEAD4: begin
                  need_in = 3'd4;
                  pv_in   = CP_W'(b[2:0]);
               end
               default: begin
                  sbad_in = 1'b1;
               end
            endcase
            if (need_in != 3'd0) begin
               seen_in = 3'd1;
               pbad_in = 1'b0;
            end
         end else begin
            // continuation byte: gather six bits, judge at the last byte
            pbad_in = pbad_ff || cont_bad;
            pv_in   = pv_shift;
            seen_in = seen_inc;
            if (seen_inc >= need_ff) begin
               if (pbad_in) begin
                  sbad_in = 1'b1;
               end else begin
                  done = 1'b1;
                  cp   = pv_shift;
                  len  = need_ff;
               end
               need_in = 3'd0;
               seen_in = 3'd0;
               pbad_in = 1'b0;
               pv_in   = '0;
            end
         end
         // count the character and track the target
         if (done) begin
            if (!saturated && count_x <= 33'h0FFFF && cp == target_ff) begin
               if (!ffound_ff) begin
                  ffound_in = 1'b1;
                  fpos_in   = count_x[IDX_W-1:0];
               end
               lfound_in = 1'b1;
               lpos_in   = count_x[IDX_W-1:0];
            end
            if (!saturated) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
      if (sbad_in) begin
         status = utf8ds_pkg::STATUS_INVALID;
      end else if (q_entry.eos && need_in != 3'd0) begin
         status = utf8ds_pkg::STATUS_TRUNC;
      end else begin
         status = utf8ds_pkg::STATUS_OK;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // decoder state, cleared at the end of each string
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff     <= '0;
         need_ff   <= '0;
         seen_ff   <= '0;
         pbad_ff   <= 1'b0;
         sbad_ff   <= 1'b0;
         count_ff  <= '0;
         ffound_ff <= 1'b0;
         fpos_ff   <= '0;
         lfound_ff <= 1'b0;
         lpos_ff   <= '0;
      end else if (q_pop) begin
         if (q_entry.eos) begin
            pv_ff     <= '0;
            need_ff   <= '0;
            seen_ff   <= '0;
            pbad_ff   <= 1'b0;
            sbad_ff   <= 1'b0;
            count_ff  <= '0;
            ffound_ff <= 1'b0;
            fpos_ff   <= '0;
            lfound_ff <= 1'b0;
            lpos_ff   <= '0;
         end else begin
            pv_ff     <= pv_in;
            need_ff   <= need_in;
            seen_ff   <= seen_in;
            pbad_ff   <= pbad_in;
            sbad_ff   <= sbad_in;
            count_ff  <= count_in;
            ffound_ff <= ffound_in;
            fpos_ff   <= fpos_in;
            lfound_ff <= lfound_in;
            lpos_ff   <= lpos_in;
         end
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         done_ff    <= done;
         cp_ff      <= cp;
         len_ff     <= len;
         status_ff  <= status;
         eos_ff     <= q_entry.eos;
         ocount_ff  <= 17'(count_in);
         ofound_ff  <= ffound_in;
         ofpos_ff   <= fpos_in;
         olfound_ff <= lfound_in;
         olpos_ff   <= lpos_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_done   = done_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_char_bytes  = len_ff;
   assign rsp_status      = status_ff;
   assign rsp_string_done = eos_ff;
   assign rsp_char_count  = ocount_ff;
   assign rsp_first_found = ofound_ff;
   assign rsp_first_index = ofpos_ff;
   assign rsp_last_found  = olfound_ff;
   assign rsp_last_index  = olpos_ff;

   // checks
   `ASSERT_CHK(a_done_len, !(valid_ff && done_ff) || (len_ff != 3'd0 && status_ff == utf8ds_pkg::STATUS_OK), "character completed with no length or bad status")
   `ASSERT_CHK(a_seq_bounds, need_ff == 3'd0 || (seen_ff != 3'd0 && seen_ff < need_ff), "bytes seen out of range for open sequence")
   `ASSERT_NEXT(a_eos_clear, q_pop && q_entry.eos, need_ff == 3'd0 && count_ff == '0 && !sbad_ff, "state not cleared after end of string")
   `ASSERT_NEXT(a_count_mono, q_pop && !q_entry.eos, count_ff >= $past(count_ff), "character count went down inside a string")

endmodule

/* rtl/utf8_decode_scan.sv */
// utf8_decode_scan: top level, joins the classifying front, the byte queue and the decoder
// depends on utf8ds_pkg, utf8ds_front, utf8ds_queue and utf8ds_back
`timescale 1ns / 1ps

// Streaming UTF-8 decoder. Bytes enter on the req_ channel, one result per
// byte leaves on the rsp_ channel, in order. The block sustains one byte per
// clock while rsp_ready stays high. Each byte is written into the two-entry
// byte queue when it is taken, and the decoder step then moves its result
// into the result register, from which it is presented. The rate is set by
// the decoder step, which reads the state the previous byte left. While the
// result waits, up to two more bytes are taken into the queue before req_ready
// drops. The character count saturates at MAX_CHARS. csr_wr_data sets the
// target code point whose first and last character indices are reported;
// write it only while no byte is in flight.
module utf8_decode_scan #(
   parameter longint unsigned MAX_CHARS = utf8ds_pkg::MAX_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [20:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_char_done,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_char_bytes,
   output logic [1:0]  rsp_status,
   output logic        rsp_string_done,
   output logic [16:0] rsp_char_count,
   output logic        rsp_first_found,
   output logic [15:0] rsp_first_index,
   output logic        rsp_last_found,
   output logic [15:0] rsp_last_index
);

   logic                  push;
   logic                  push_ready;
   utf8ds_pkg::entry_type push_entry;
   logic                  pop;
   logic                  pop_valid;
   utf8ds_pkg::entry_type pop_entry;

   // byte classification
   utf8ds_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .q_ready           (push_ready),
      .q_push            (push),
      .q_entry           (push_entry)
   );

   // queue between front and back
   utf8ds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // decoder and result register
   utf8ds_back #(
      .MAX_CHARS (MAX_CHARS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_valid         (pop_valid),
      .q_entry         (pop_entry),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_done   (rsp_char_done),
      .rsp_code_point  (rsp_code_point),
      .rsp_char_bytes  (rsp_char_bytes),
      .rsp_status      (rsp_status),
      .rsp_string_done (rsp_string_done),
      .rsp_char_count  (rsp_char_count),
      .rsp_first_found (rsp_first_found),
      .rsp_first_index (rsp_first_index),
      .rsp_last_found  (rsp_last_found),
      .rsp_last_index  (rsp_last_index)
   );

endmodule
